// ----- design/hvs_pkg.sv -----
// Shared constants, widths and control types of the vector similarity block.
// No dependencies; every other file of the block imports it.
package hvs_pkg;

	// longest vector that is counted exactly; every count saturates here
	localparam int unsigned MAX_LENGTH = 16384;

	localparam int CNT_W  = 15;	// counts 0..MAX_LENGTH
	localparam int DOT_W  = 16;	// signed dot product, +-MAX_LENGTH
	localparam int PROD_W = 29;	// product of two counts, up to MAX_LENGTH squared
	localparam int QUO_W  = 31;	// cosine squared in Q1.30
	localparam int ROOT_W = 16;	// root result, up to 1.0 in Q1.15
	localparam int RAD_W  = 32;	// radicand, padded to an even width
	localparam int SREM_W = ROOT_W + 2;
	localparam int STEP_W = 5;

	localparam int IN_W       = 8;
	localparam int OUT_W      = 48;
	localparam int OUT_USER_W = 2;

	localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_LENGTH);
	localparam logic [15:0]       COS_MAX = 16'h7FFF;
	localparam logic [14:0]       JAC_MAX = 15'h7FFF;

	// last value of the step counter: 31 divide steps, 16 root steps
	localparam logic [STEP_W-1:0] COS_DIV_LAST = STEP_W'(QUO_W - 1);
	localparam logic [STEP_W-1:0] ROOT_LAST    = STEP_W'(ROOT_W - 1);

	typedef struct packed {
		logic [DOT_W-1:0] dot;
		logic [CNT_W-1:0] nz_a;
		logic [CNT_W-1:0] nz_b;
		logic [CNT_W-1:0] mismatch;
		logic [CNT_W-1:0] both_one;
		logic [CNT_W-1:0] either_one;
	} acc_t;

	typedef struct packed {
		logic acc_en;
		logic snap;
		logic mul_sq;
		logic mul_nz;
		logic div_load_cos;
		logic div_load_jac;
		logic div_step;
		logic root_load;
		logic root_step;
		logic out_load;
	} cmd_t;

endpackage

// ----- design/hvs_ctrl.sv -----
// Sequencer of the similarity block: input handshake, arithmetic schedule
// and output valid. Depends on hvs_pkg.
module hvs_ctrl import hvs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tlast,
	output logic s_tready,
	input  logic m_tready,
	output logic m_tvalid,
	output cmd_t cmd
);

	typedef enum logic [8:0] {
		S_ACC  = 9'b000000001,
		S_SNAP = 9'b000000010,
		S_MSQ  = 9'b000000100,
		S_MNZ  = 9'b000001000,
		S_LDC  = 9'b000010000,
		S_DIVC = 9'b000100000,
		S_LDJ  = 9'b001000000,
		S_ROOT = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t              state_q, state_d;
	logic [STEP_W-1:0]   cnt_q, cnt_d;
	logic                out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_ACC: begin
				s_tready   = 1'b1;
				cmd.acc_en = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_d = S_SNAP;
				end
			end
			S_SNAP: begin
				cmd.snap = 1'b1;
				state_d  = S_MSQ;
			end
			S_MSQ: begin
				cmd.mul_sq = 1'b1;
				state_d    = S_MNZ;
			end
			S_MNZ: begin
				cmd.mul_nz = 1'b1;
				state_d    = S_LDC;
			end
			S_LDC: begin
				cmd.div_load_cos = 1'b1;
				cnt_d            = COS_DIV_LAST;
				state_d          = S_DIVC;
			end
			S_DIVC: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = S_LDJ;
				end
			end
			S_LDJ: begin
				// root of the cosine square runs beside the jaccard divide
				cmd.div_load_jac = 1'b1;
				cmd.root_load    = 1'b1;
				cnt_d            = ROOT_LAST;
				state_d          = S_ROOT;
			end
			S_ROOT: begin
				cmd.div_step  = 1'b1;
				cmd.root_step = 1'b1;
				cnt_d         = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_ACC;
				end
			end
			default: begin
				state_d = S_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ----- design/hvs_accum.sv -----
// Running accumulators over the element pairs of one vector.
// Depends on hvs_pkg for widths, saturation limit and the command struct.
module hvs_accum import hvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic [1:0] elem_a,
	input  logic [1:0] elem_b,
	output acc_t       acc
);

	localparam logic signed [DOT_W:0] DOT_HI   = (DOT_W+1)'(MAX_LENGTH);
	localparam logic signed [DOT_W:0] DOT_LO   = -DOT_HI;
	localparam logic signed [DOT_W:0] DOT_STEP = (DOT_W+1)'(1);

	acc_t acc_q, acc_d;

	logic a_nz, b_nz, a_neg, b_neg, a_one, b_one;
	logic prod_pos, prod_neg, differ;
	logic signed [DOT_W:0] dot_sum;

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c, input logic en);
		count_up = (en && (c < CNT_MAX)) ? c + 1'b1 : c;
	endfunction

	// both codes with the top bit set decode as -1
	assign a_nz  = |elem_a;
	assign b_nz  = |elem_b;
	assign a_neg = elem_a[1];
	assign b_neg = elem_b[1];
	assign a_one = (elem_a == 2'b01);
	assign b_one = (elem_b == 2'b01);

	assign prod_pos = a_nz && b_nz && (a_neg == b_neg);
	assign prod_neg = a_nz && b_nz && (a_neg != b_neg);
	assign differ   = (a_nz != b_nz) || prod_neg;

	always_comb begin
		dot_sum = $signed({acc_q.dot[DOT_W-1], acc_q.dot});
		if (prod_pos) begin
			dot_sum = dot_sum + DOT_STEP;
		end else if (prod_neg) begin
			dot_sum = dot_sum - DOT_STEP;
		end
		acc_d            = acc_q;
		if (dot_sum > DOT_HI) begin
			acc_d.dot = DOT_HI[DOT_W-1:0];
		end else if (dot_sum < DOT_LO) begin
			acc_d.dot = DOT_LO[DOT_W-1:0];
		end else begin
			acc_d.dot = dot_sum[DOT_W-1:0];
		end
		acc_d.nz_a       = count_up(acc_q.nz_a, a_nz);
		acc_d.nz_b       = count_up(acc_q.nz_b, b_nz);
		acc_d.mismatch   = count_up(acc_q.mismatch, differ);
		acc_d.both_one   = count_up(acc_q.both_one, a_one && b_one);
		acc_d.either_one = count_up(acc_q.either_one, a_one || b_one);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.snap) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_d;
		end
	end

	assign acc = acc_q;

endmodule

// ----- design/hvs_calc.sv -----
// End-of-vector arithmetic: shared multiplier, restoring divider, digit
// square root and the result register. Depends on hvs_pkg.
module hvs_calc import hvs_pkg::*; (
	input  logic               clk,
	input  cmd_t               cmd,
	input  acc_t               acc,
	output logic [14:0]        hamming_distance,
	output logic signed [15:0] cosine,
	output logic               cosine_undefined,
	output logic [14:0]        jaccard,
	output logic               jaccard_undefined
);

	// snapshot of the finished vector
	logic [CNT_W-1:0] mag_q, nza_q, nzb_q, ham_q, both_q, either_q;
	logic             neg_q, cund_q, jund_q;
	logic [DOT_W-1:0] dot_abs;

	// multiplier
	logic [CNT_W-1:0]   mul_a, mul_b;
	logic [2*CNT_W-1:0] mul_res;
	logic [PROD_W-1:0]  sq_q, prod_q;

	// divider
	logic [PROD_W-1:0] den_q, rem_q;
	logic              nbit_q;
	logic [QUO_W-1:0]  quo_q;
	logic [PROD_W:0]   div_trial, div_diff;
	logic              div_ge;

	// square root
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W-1:0] srem_q;
	logic [SREM_W+1:0] rt_pre, rt_sub, rt_diff;
	logic              rt_ge;

	logic [15:0] cos_d;
	logic [14:0] jac_d;

	assign dot_abs = acc.dot[DOT_W-1] ? (~acc.dot + 1'b1) : acc.dot;

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			mag_q    <= dot_abs[CNT_W-1:0];
			neg_q    <= acc.dot[DOT_W-1];
			nza_q    <= acc.nz_a;
			nzb_q    <= acc.nz_b;
			ham_q    <= acc.mismatch;
			both_q   <= acc.both_one;
			either_q <= acc.either_one;
			cund_q   <= (acc.nz_a == '0) || (acc.nz_b == '0);
			jund_q   <= (acc.either_one == '0);
		end
	end

	assign mul_a   = cmd.mul_sq ? mag_q : nza_q;
	assign mul_b   = cmd.mul_sq ? mag_q : nzb_q;
	assign mul_res = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_sq) begin
			sq_q <= mul_res[PROD_W-1:0];
		end
		if (cmd.mul_nz) begin
			prod_q <= mul_res[PROD_W-1:0];
		end
	end

	// one quotient bit a cycle; the dividend is the loaded value followed by zeros
	assign div_trial = {rem_q, nbit_q};
	assign div_diff  = div_trial - {1'b0, den_q};
	assign div_ge    = (div_trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load_cos) begin
			rem_q  <= {1'b0, sq_q[PROD_W-1:1]};
			nbit_q <= sq_q[0];
			den_q  <= prod_q;
			quo_q  <= '0;
		end else if (cmd.div_load_jac) begin
			rem_q  <= PROD_W'(both_q >> 1);
			nbit_q <= both_q[0];
			den_q  <= PROD_W'(either_q);
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= div_ge ? div_diff[PROD_W-1:0] : div_trial[PROD_W-1:0];
			nbit_q <= 1'b0;
			quo_q  <= {quo_q[QUO_W-2:0], div_ge};
		end
	end

	// two radicand bits a cycle, one root bit out
	assign rt_pre  = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign rt_sub  = {2'b00, root_q, 2'b01};
	assign rt_diff = rt_pre - rt_sub;
	assign rt_ge   = (rt_pre >= rt_sub);

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			rad_q  <= RAD_W'(quo_q);
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], rt_ge};
			srem_q <= rt_ge ? rt_diff[SREM_W-1:0] : rt_pre[SREM_W-1:0];
		end
	end

	always_comb begin
		if (cund_q) begin
			cos_d = '0;
		end else if (neg_q) begin
			cos_d = ~root_q + 1'b1;
		end else if (root_q[ROOT_W-1]) begin
			cos_d = COS_MAX;
		end else begin
			cos_d = root_q;
		end
		if (jund_q) begin
			jac_d = '0;
		end else if (quo_q[15]) begin
			jac_d = JAC_MAX;
		end else begin
			jac_d = quo_q[14:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			hamming_distance  <= ham_q;
			cosine            <= $signed(cos_d);
			cosine_undefined  <= cund_q;
			jaccard           <= jac_d;
			jaccard_undefined <= jund_q;
		end
	end

endmodule

// ----- design/hd_vector_similarity.sv -----
// Top level of the vector similarity block: sequencer, accumulators and
// end-of-vector arithmetic. Depends on hvs_pkg, hvs_ctrl, hvs_accum, hvs_calc.
//
// Element pairs stream in one word per cycle; each element is -1, 0 or 1 and
// tlast marks the final pair. Every pair except the last is taken at full
// rate. After the last pair the block drops s_tready and works out the result
// (Hamming distance, cosine in signed Q1.15, Jaccard ratio in Q0.15, and the
// two undefined flags) with the 31-step restoring divide for the cosine
// square and the 16-step square root that runs beside the Jaccard divide.
// The result waits in an output register, and the next vector may start
// streaming while it waits.
module hd_vector_similarity import hvs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,	// elem_a[1:0], elem_b[3:2], zero pad
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,	// hamming_distance[14:0], cosine[30:15],
						// jaccard[45:31], zero pad
	output logic [OUT_USER_W-1:0] m_tuser	// cosine_undefined[0], jaccard_undefined[1]
);

	cmd_t               cmd;
	acc_t               acc;
	logic [14:0]        hamming_distance;
	logic signed [15:0] cosine;
	logic               cosine_undefined;
	logic [14:0]        jaccard;
	logic               jaccard_undefined;

	hvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	hvs_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.elem_a (s_tdata[1:0]),
		.elem_b (s_tdata[3:2]),
		.acc    (acc)
	);

	hvs_calc u_calc (
		.clk               (clk),
		.cmd               (cmd),
		.acc               (acc),
		.hamming_distance  (hamming_distance),
		.cosine            (cosine),
		.cosine_undefined  (cosine_undefined),
		.jaccard           (jaccard),
		.jaccard_undefined (jaccard_undefined)
	);

	assign m_tdata = {2'b00, jaccard, cosine, hamming_distance};
	assign m_tuser = {jaccard_undefined, cosine_undefined};

	// a last word stops intake until the result is loaded
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input taken right after a last word");

	a_cos_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[30:15] == 16'h0000))
		else $error("cosine not zero while undefined");

	a_jac_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata[45:31] == 15'h0000))
		else $error("jaccard not zero while undefined");

	a_ham_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:0] <= CNT_MAX))
		else $error("hamming distance beyond saturation limit");

endmodule
